// File: sv/salc_pkg.sv
// Shared types and constants for the set-associative LRU write-back cache.
// Holds the row layout, the state machine type and the port widths.
// No dependencies.
package salc_pkg;

   localparam int MAX_SET_BITS   = 8;
   localparam int MAX_WAYS       = 8;
   localparam int MAX_BLOCK_BITS = 16;

   localparam int SET_COUNT   = 1 << MAX_SET_BITS;
   localparam int SET_IDX_W   = MAX_SET_BITS;
   localparam int WAY_IDX_W   = $clog2(MAX_WAYS);
   localparam int WAY_CNT_W   = $clog2(MAX_WAYS + 1);
   localparam int RANK_W      = 3;
   localparam int RANK_MAX    = (1 << RANK_W) - 1;
   localparam int TAG_W       = 64;
   localparam int ADDR_W      = 64;
   localparam int SHAMT_W     = 6;
   localparam int BLOCK_SZ_W  = MAX_BLOCK_BITS + 1;

   localparam int CNT_W       = 32;
   localparam int HELD_W      = 28;

   localparam int REQ_TDATA_W = 64;
   localparam int RSP_FIELD_W = 2 + 3 + CNT_W * 3 + HELD_W + CNT_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 5;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAY_COUNT  = 2'd2;

   // Access kinds.
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_STORE = 1'b1;

   typedef enum logic [1:0] {
      OUT_HIT         = 2'd0,
      OUT_FILL        = 2'd1,
      OUT_EVICT_CLEAN = 2'd2,
      OUT_EVICT_DIRTY = 2'd3
   } outcome_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_UPDATE = 1'b1
   } state_type;

   typedef struct packed {
      logic              valid;
      logic              dirty;
      logic [RANK_W-1:0] rank;
      logic [TAG_W-1:0]  tag;
   } way_entry_type;

   typedef way_entry_type [MAX_WAYS-1:0] set_row_type;

   typedef struct packed {
      logic                 en;
      logic [SET_IDX_W-1:0] set;
   } row_rd_type;

   typedef struct packed {
      logic                 en;
      logic [SET_IDX_W-1:0] set;
      set_row_type          row;
   } row_wr_type;

endpackage

// File: sv/salc_set_store.sv
// Set row memory: one row per set holding every way's valid, dirty, rank and tag.
// A flip-flop per row marks rows written since reset; others read as empty.
// Depends on salc_pkg.
module salc_set_store
   import salc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  row_rd_type  rd_req,
   input  row_wr_type  wr_req,
   output set_row_type rd_row
);

   set_row_type          mem [SET_COUNT];
   logic [SET_COUNT-1:0] row_valid_ff;
   set_row_type          rd_data_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[wr_req.set] <= wr_req.row;
      end
      if (rd_req.en) begin
         rd_data_ff <= mem[rd_req.set];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_req.en) begin
            row_valid_ff[wr_req.set] <= 1'b1;
         end
         if (rd_req.en) begin
            rd_valid_ff <= row_valid_ff[rd_req.set];
         end
      end
   end

   // A row never written since reset reads as all ways invalid, clean, rank zero.
   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

`ifndef NO_ASSERTIONS
   // The controller never reads a row in the cycle it writes one back.
   a_no_rd_wr_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rd_req.en && wr_req.en))
      else $error("row read and write issued in the same cycle");

   // A row read carries the written mark of the row it addressed.
   a_rd_mark: assert property (@(posedge clock) disable iff (reset)
      rd_req.en |=> (rd_valid_ff == $past(row_valid_ff[rd_req.set])))
      else $error("row read returned the wrong written mark");

   // A row write marks its row as holding data.
   a_wr_mark: assert property (@(posedge clock) disable iff (reset)
      wr_req.en |=> row_valid_ff[$past(wr_req.set)])
      else $error("written row not marked");
`endif

endmodule

// File: sv/set_assoc_lru_writeback_cache.sv
// Top level of the set-associative cache model with LRU replacement and write-back
// dirty tracking. Holds configuration, the access state machine and counters.
// Depends on salc_pkg and salc_set_store.
//
//   Channel   Direction  Handshake           Contents
//   req_*     in         tvalid/tready       tuser: action; tdata: address
//   rsp_*     out        tvalid/tready       tdata: outcome, way, five counters
//   csr_*     in         csr_we (no wait)    csr_index, csr_wdata
//
// Each access has an accept step and an update step: the beat is accepted and its
// set row is read from the row memory, then the row is compared, updated and
// written back while the result is loaded into the output register. The registered
// read of the row memory is what separates them. A new request is accepted in the
// cycle after a write-back even while the previous result still waits in the output
// register; a finished access holds in the update cycle only if that register is
// still full. Reset is synchronous; rows read as empty right after it.
module set_assoc_lru_writeback_cache
   import salc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [63:0] address
   input  logic                   req_tuser,   // [0] action (0 load, 1 store)
   // Result channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [1:0] outcome, [4:2] way_used,
                                               // [36:5] hit_total, [68:37] miss_total,
                                               // [100:69] eviction_total,
                                               // [128:101] dirty_bytes_held,
                                               // [160:129] dirty_bytes_evicted, rest 0
   // Configuration port.
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers.
   logic [3:0] set_bits_ff;
   logic [4:0] block_bits_ff;
   logic [3:0] way_count_ff;

   // Configuration as used, with out-of-range values clamped.
   logic [3:0]           set_bits_use;
   logic [4:0]           block_bits_use;
   logic [WAY_CNT_W-1:0] way_count_use;
   logic [BLOCK_SZ_W-1:0] block_size;

   state_type state_ff, state_in;
   logic      req_fire;
   logic      update_fire;
   logic      out_free;

   // Request captured at acceptance.
   logic [TAG_W-1:0]     tag_ff;
   logic                 store_ff;
   logic [SET_IDX_W-1:0] set_ff;

   logic [SET_IDX_W-1:0] req_set;
   logic [TAG_W-1:0]     req_tag;
   logic [SHAMT_W-1:0]   tag_shamt;

   // Counters.
   logic [CNT_W-1:0]  hit_total_ff,  hit_total_in;
   logic [CNT_W-1:0]  miss_total_ff, miss_total_in;
   logic [CNT_W-1:0]  evict_total_ff, evict_total_in;
   logic [HELD_W-1:0] held_ff, held_in;
   logic [CNT_W-1:0]  evicted_bytes_ff, evicted_bytes_in;

   // Output register.
   logic                   rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // Row memory interface.
   row_rd_type  rd_req;
   row_wr_type  wr_req;
   set_row_type cur_row;
   set_row_type new_row;

   // Lookup results.
   logic [MAX_WAYS-1:0]  in_use, hit_vec, empty_vec;
   logic                 hit_any, empty_any;
   logic [WAY_IDX_W-1:0] hit_way, empty_way, victim_way, sel_way;
   logic [RANK_W:0]      old_rank;
   outcome_type          outcome;
   logic                 dirty_evict;

   // ---------------------------------------------------------------------------
   // Configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= 4'd0;
         block_bits_ff <= 5'd0;
         way_count_ff  <= 4'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SET_BITS:   set_bits_ff   <= csr_wdata[3:0];
            CSR_BLOCK_BITS: block_bits_ff <= csr_wdata[4:0];
            CSR_WAY_COUNT:  way_count_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      set_bits_use   = (set_bits_ff > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : set_bits_ff;
      block_bits_use = (block_bits_ff > 5'(MAX_BLOCK_BITS)) ? 5'(MAX_BLOCK_BITS)
                                                            : block_bits_ff;
      if (way_count_ff == 4'd0) begin
         way_count_use = WAY_CNT_W'(1);
      end else if (way_count_ff > 4'(MAX_WAYS)) begin
         way_count_use = WAY_CNT_W'(MAX_WAYS);
      end else begin
         way_count_use = WAY_CNT_W'(way_count_ff);
      end
      block_size = BLOCK_SZ_W'(1) << block_bits_use;
   end

   // ---------------------------------------------------------------------------
   // Address split: offset in the low bits, then the set index, then the tag.
   always_comb begin
      tag_shamt = SHAMT_W'(set_bits_use) + SHAMT_W'(block_bits_use);
      req_set   = SET_IDX_W'((req_tdata >> block_bits_use)
                             & ((64'd1 << set_bits_use) - 64'd1));
      req_tag   = req_tdata >> tag_shamt;
   end

   // ---------------------------------------------------------------------------
   // State machine: accept and read, then update and write back.
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_UPDATE;
         ST_UPDATE: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = (state_ff == ST_IDLE) && !reset;
      req_fire    = req_tvalid && req_tready;
      update_fire = (state_ff == ST_UPDATE) && out_free;
      rd_req.en   = req_fire;
      rd_req.set  = req_set;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         tag_ff   <= req_tag;
         store_ff <= req_tuser;
         set_ff   <= req_set;
      end
   end

   salc_set_store u_set_store (
      .clock  (clock),
      .reset  (reset),
      .rd_req (rd_req),
      .wr_req (wr_req),
      .rd_row (cur_row)
   );

   // ---------------------------------------------------------------------------
   // Lookup: first matching way in use, else first empty way, else the way with
   // the highest rank (lowest index wins a tie).
   always_comb begin
      for (int i = 0; i < MAX_WAYS; i++) begin
         in_use[i]    = WAY_CNT_W'(i) < way_count_use;
         hit_vec[i]   = in_use[i] && cur_row[i].valid && (cur_row[i].tag == tag_ff);
         empty_vec[i] = in_use[i] && !cur_row[i].valid;
      end
      hit_any   = |hit_vec;
      empty_any = |empty_vec;

      hit_way   = '0;
      empty_way = '0;
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (hit_vec[i]) hit_way = WAY_IDX_W'(i);
         if (empty_vec[i]) empty_way = WAY_IDX_W'(i);
      end

      victim_way = '0;
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (in_use[i] && (cur_row[i].rank > cur_row[victim_way].rank)) begin
            victim_way = WAY_IDX_W'(i);
         end
      end

      if (hit_any) begin
         sel_way  = hit_way;
         outcome  = OUT_HIT;
         old_rank = {1'b0, cur_row[hit_way].rank};
      end else if (empty_any) begin
         sel_way  = empty_way;
         outcome  = OUT_FILL;
         // A fill into an empty way ages every valid way in use.
         old_rank = (RANK_W + 1)'(RANK_MAX + 1);
      end else begin
         sel_way  = victim_way;
         outcome  = cur_row[victim_way].dirty ? OUT_EVICT_DIRTY : OUT_EVICT_CLEAN;
         old_rank = {1'b0, cur_row[victim_way].rank};
      end
      dirty_evict = (outcome == OUT_EVICT_DIRTY);
   end

   // Row update: age the ways more recent than the accessed one, then make the
   // accessed way most recent and apply the fill or the store.
   always_comb begin
      new_row = cur_row;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if ((WAY_IDX_W'(i) != sel_way) && in_use[i] && cur_row[i].valid
             && ({1'b0, cur_row[i].rank} < old_rank)
             && (cur_row[i].rank != RANK_W'(RANK_MAX))) begin
            new_row[i].rank = cur_row[i].rank + RANK_W'(1);
         end
      end
      new_row[sel_way].rank = '0;
      if (!hit_any) begin
         new_row[sel_way].valid = 1'b1;
         new_row[sel_way].tag   = tag_ff;
         new_row[sel_way].dirty = (store_ff == ACT_STORE);
      end else if (store_ff == ACT_STORE) begin
         new_row[sel_way].dirty = 1'b1;
      end

      wr_req.en  = update_fire;
      wr_req.set = set_ff;
      wr_req.row = new_row;
   end

   // ---------------------------------------------------------------------------
   // Counters. The dirty byte count first gives up an evicted dirty block, then
   // takes on the block a store makes dirty.
   always_comb begin
      logic [HELD_W-1:0]  held_after_evict;
      logic [BLOCK_SZ_W-1:0] held_add;
      logic [HELD_W:0]    held_sum;
      logic [CNT_W:0]     ev_sum;

      hit_total_in     = hit_total_ff;
      miss_total_in    = miss_total_ff;
      evict_total_in   = evict_total_ff;
      evicted_bytes_in = evicted_bytes_ff;

      if (hit_any) begin
         if (hit_total_ff != '1) hit_total_in = hit_total_ff + CNT_W'(1);
      end else begin
         if (miss_total_ff != '1) miss_total_in = miss_total_ff + CNT_W'(1);
         if (!empty_any && (evict_total_ff != '1)) begin
            evict_total_in = evict_total_ff + CNT_W'(1);
         end
      end

      held_after_evict = held_ff;
      if (dirty_evict) begin
         held_after_evict = (held_ff > HELD_W'(block_size)) ? held_ff - HELD_W'(block_size)
                                                            : '0;
      end

      held_add = '0;
      if ((store_ff == ACT_STORE) && (!hit_any || !cur_row[hit_way].dirty)) begin
         held_add = block_size;
      end
      held_sum = {1'b0, held_after_evict} + (HELD_W + 1)'(held_add);
      held_in  = held_sum[HELD_W] ? '1 : held_sum[HELD_W-1:0];

      ev_sum = {1'b0, evicted_bytes_ff} + (CNT_W + 1)'(block_size);
      if (dirty_evict) begin
         evicted_bytes_in = ev_sum[CNT_W] ? '1 : ev_sum[CNT_W-1:0];
      end

      rsp_tdata_in = RSP_TDATA_W'({evicted_bytes_in, held_in, evict_total_in,
                                   miss_total_in, hit_total_in, 3'(sel_way), outcome});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_total_ff     <= '0;
         miss_total_ff    <= '0;
         evict_total_ff   <= '0;
         held_ff          <= '0;
         evicted_bytes_ff <= '0;
      end else if (update_fire) begin
         hit_total_ff     <= hit_total_in;
         miss_total_ff    <= miss_total_in;
         evict_total_ff   <= evict_total_in;
         held_ff          <= held_in;
         evicted_bytes_ff <= evicted_bytes_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (update_fire) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (update_fire) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef NO_ASSERTIONS
   // An accepted request always moves on to the update cycle.
   a_accept_to_update: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_UPDATE))
      else $error("accepted request did not reach the update cycle");

   // A result only appears out of an update cycle.
   a_result_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("result raised outside an update");

   // The miss counter never moves by more than one per cycle.
   a_miss_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((miss_total_ff == $past(miss_total_ff))
                || (miss_total_ff == $past(miss_total_ff) + CNT_W'(1))))
      else $error("miss counter jumped");

   // An access is counted as a hit or as a miss, never both.
   a_hit_xor_miss: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> !((hit_total_ff != $past(hit_total_ff))
                 && (miss_total_ff != $past(miss_total_ff))))
      else $error("hit and miss counted for one access");
`endif

endmodule
